// ===== rtl/core/bscm_pkg.sv =====
// Shared types, constants and helpers for the battery state change monitor.
package bscm_pkg;

  localparam int CLIENTS   = 8;
  localparam int CLIENT_W  = 3;
  localparam int FRAC_BITS = 8;
  localparam int AVG_W     = 25;              // common average width inside a tracker
  localparam int TAVG_W    = 24;              // stored temperature average width
  localparam int MAG_W     = 24;              // magnitude of sample minus average
  localparam int TIME_W    = 32;
  localparam int TAU_W     = 16;
  localparam int THR_W     = 16;
  localparam int PROD_W    = MAG_W + TIME_W;
  localparam int DVS_W     = TIME_W + 1;
  localparam int EV_W      = 9;

  // Command codes
  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_RESET  = 2'd2;
  localparam logic [1:0] CMD_PEEK   = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_TEMP_THR = 2'd0;
  localparam logic [1:0] REG_TEMP_TAU = 2'd1;
  localparam logic [1:0] REG_VOLT_THR = 2'd2;
  localparam logic [1:0] REG_VOLT_TAU = 2'd3;

  localparam logic [11:0] TEMP_THR_RST = 12'd80;
  localparam logic [15:0] TEMP_TAU_RST = 16'd5000;
  localparam logic [15:0] VOLT_THR_RST = 16'd500;
  localparam logic [15:0] VOLT_TAU_RST = 16'd5000;

  // Event bit positions
  localparam int EV_CHARGE = 0;
  localparam int EV_TEMP   = 1;
  localparam int EV_VOLT   = 2;
  localparam int EV_USB    = 3;
  localparam int EV_WLS    = 4;
  localparam int EV_SUPPLY = 5;
  localparam int EV_CSTAT  = 6;
  localparam int EV_SENSOR = 7;
  localparam int EV_LIMIT  = 8;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         client;
    logic [31:0]        now_ms;
    logic [6:0]         charge_percent;
    logic signed [11:0] temperature;
    logic [15:0]        open_volts;
    logic               usb_present;
    logic               wireless_present;
    logic [3:0]         supply_status;
    logic [2:0]         charge_status;
    logic               sensor_present;
    logic               charge_limited;
  } req_t;

  typedef struct packed {
    logic any_pending;
    logic charge_changed;
    logic temp_jump;
    logic volt_jump;
    logic usb_changed;
    logic wireless_changed;
    logic supply_changed;
    logic charge_status_changed;
    logic sensor_changed;
    logic limit_changed;
  } rsp_t;

  typedef struct packed {
    logic signed [AVG_W-1:0] sample;
    logic signed [AVG_W-1:0] avg;
    logic [TIME_W-1:0]       stamp;
    logic [TIME_W-1:0]       now;
    logic [THR_W-1:0]        thr;
    logic [TAU_W-1:0]        tau;
  } trk_op_t;

  typedef struct packed {
    logic signed [AVG_W-1:0] avg;
    logic [TIME_W-1:0]       stamp;
    logic                    jump;
  } trk_res_t;

  function automatic rsp_t to_rsp(input logic [EV_W-1:0] ev);
    rsp_t r;
    r.any_pending           = |ev;
    r.charge_changed        = ev[EV_CHARGE];
    r.temp_jump             = ev[EV_TEMP];
    r.volt_jump             = ev[EV_VOLT];
    r.usb_changed           = ev[EV_USB];
    r.wireless_changed      = ev[EV_WLS];
    r.supply_changed        = ev[EV_SUPPLY];
    r.charge_status_changed = ev[EV_CSTAT];
    r.sensor_changed        = ev[EV_SENSOR];
    r.limit_changed         = ev[EV_LIMIT];
    return r;
  endfunction

endpackage

// ===== rtl/core/bscm_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface bscm_req_if;
  logic             valid;
  logic             ready;
  bscm_pkg::req_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bscm_rsp_if;
  logic             valid;
  logic             ready;
  bscm_pkg::rsp_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/bscm_track.sv =====
// Moving average: bit-serial multiply by dt, divide by tau+dt; or seed, hold or snap.
module bscm_track (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  bscm_pkg::trk_op_t   op_in,
  output bscm_pkg::trk_res_t  res,
  output logic                done
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIVI = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_ADJ  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]                      state;
  bscm_pkg::trk_op_t               op;
  logic [bscm_pkg::MAG_W-1:0]      mag_sr;
  logic                            neg;
  logic [bscm_pkg::TIME_W-1:0]     dt_q;
  logic [bscm_pkg::DVS_W-1:0]      dvs;
  logic [bscm_pkg::PROD_W-1:0]     prod;
  logic [bscm_pkg::DVS_W-1:0]      rem;
  logic [bscm_pkg::MAG_W-1:0]      lo;
  logic [bscm_pkg::MAG_W-1:0]      quo;
  logic [4:0]                      cnt;

  logic signed [bscm_pkg::AVG_W:0] diff;
  logic [bscm_pkg::AVG_W:0]        diff_abs;
  logic [bscm_pkg::MAG_W-1:0]      mag;
  logic [bscm_pkg::MAG_W-1:0]      thr_s;
  logic [bscm_pkg::TIME_W-1:0]     dt;
  logic [bscm_pkg::DVS_W:0]        trial;
  logic [bscm_pkg::DVS_W:0]        trial_sub;

  // Evaluate the deviation and elapsed time from the latched operands
  always_comb begin
    diff      = {op.sample[bscm_pkg::AVG_W-1], op.sample} - {op.avg[bscm_pkg::AVG_W-1], op.avg};
    diff_abs  = diff[bscm_pkg::AVG_W] ? (~diff + 1'b1) : diff;
    mag       = diff_abs[bscm_pkg::MAG_W-1:0];
    thr_s     = {op.thr, {bscm_pkg::FRAC_BITS{1'b0}}};
    dt        = op.now - op.stamp;
    trial     = {rem, lo[bscm_pkg::MAG_W-1]};
    trial_sub = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == ST_FIN);
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            op    <= op_in;
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          res.stamp <= op.now;
          if (op.stamp == '0) begin
            // unseeded: take the sample
            res.avg  <= op.sample;
            res.jump <= 1'b0;
            state    <= ST_FIN;
          end else if (dt == '0) begin
            res.avg  <= op.avg;
            res.jump <= 1'b0;
            state    <= ST_FIN;
          end else if (mag >= thr_s) begin
            // jump: snap to the sample
            res.avg  <= op.sample;
            res.jump <= 1'b1;
            state    <= ST_FIN;
          end else begin
            res.jump <= 1'b0;
            mag_sr   <= mag;
            neg      <= diff[bscm_pkg::AVG_W];
            dt_q     <= dt;
            dvs      <= {1'b0, op.tau} + {1'b0, dt};
            prod     <= '0;
            cnt      <= '0;
            state    <= ST_MUL;
          end
        end
        ST_MUL: begin
          // shift-add one magnitude bit per cycle, MSB first
          prod   <= {prod[bscm_pkg::PROD_W-2:0], 1'b0}
                    + (mag_sr[bscm_pkg::MAG_W-1] ? bscm_pkg::PROD_W'(dt_q)
                                                  : bscm_pkg::PROD_W'(0));
          mag_sr <= {mag_sr[bscm_pkg::MAG_W-2:0], 1'b0};
          cnt    <= cnt + 5'd1;
          if (cnt == 5'(bscm_pkg::MAG_W - 1)) state <= ST_DIVI;
        end
        ST_DIVI: begin
          // quotient fits MAG_W bits, so the upper product part is below the divisor
          rem   <= {1'b0, prod[bscm_pkg::PROD_W-1:bscm_pkg::MAG_W]};
          lo    <= prod[bscm_pkg::MAG_W-1:0];
          quo   <= '0;
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          // restoring division, one quotient bit per cycle
          if (!trial_sub[bscm_pkg::DVS_W]) begin
            rem <= trial_sub[bscm_pkg::DVS_W-1:0];
            quo <= {quo[bscm_pkg::MAG_W-2:0], 1'b1};
          end else begin
            rem <= trial[bscm_pkg::DVS_W-1:0];
            quo <= {quo[bscm_pkg::MAG_W-2:0], 1'b0};
          end
          lo  <= {lo[bscm_pkg::MAG_W-2:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == 5'(bscm_pkg::MAG_W - 1)) state <= ST_ADJ;
        end
        ST_ADJ: begin
          res.avg <= neg ? op.avg - $signed({1'b0, quo}) : op.avg + $signed({1'b0, quo});
          state   <= ST_FIN;
        end
        ST_FIN: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/battery_state_change_monitor.sv =====
// Top level of the battery state change monitor: client contexts, sequencing, response register.
//
//   channel  | dir | handshake      | payload
//   req      | in  | valid/ready    | cmd, client, now_ms, sample fields
//   rsp      | out | valid/ready    | any_pending and nine event flags
//   cfg      | in  | cfg_we         | cfg_index, cfg_data
//
// One request at a time. Read, reset and peek commands go from accept to
// response without the trackers; an update waits on the bit-serial multiply
// and divide that the two trackers run in parallel, and each tracker skips both
// when it needs no divide.
// Reset clears all client contexts at once and loads register defaults.
// A new request is accepted while a finished response still waits on rsp.
module battery_state_change_monitor (
  input  logic        clk,
  input  logic        rst,
  bscm_req_if.sink    req,
  bscm_rsp_if.source  rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                          state;
  bscm_pkg::req_t                      item;
  logic [bscm_pkg::EV_W-1:0]           res_ev;
  logic                                tdone_q;
  logic                                vdone_q;
  logic                                trk_start;

  logic [11:0]                         temp_thr;
  logic [15:0]                         temp_tau;
  logic [15:0]                         volt_thr;
  logic [15:0]                         volt_tau;

  logic [6:0]                          last_charge   [bscm_pkg::CLIENTS];
  logic [3:0]                          last_flags    [bscm_pkg::CLIENTS];
  logic [3:0]                          last_supply   [bscm_pkg::CLIENTS];
  logic [2:0]                          last_cstat    [bscm_pkg::CLIENTS];
  logic [bscm_pkg::EV_W-1:0]           pending       [bscm_pkg::CLIENTS];
  logic signed [bscm_pkg::TAVG_W-1:0]  temp_avg      [bscm_pkg::CLIENTS];
  logic [bscm_pkg::TIME_W-1:0]         temp_time     [bscm_pkg::CLIENTS];
  logic signed [bscm_pkg::AVG_W-1:0]   volt_avg      [bscm_pkg::CLIENTS];
  logic [bscm_pkg::TIME_W-1:0]         volt_time     [bscm_pkg::CLIENTS];

  bscm_pkg::trk_op_t                   t_op;
  bscm_pkg::trk_op_t                   v_op;
  bscm_pkg::trk_res_t                  t_res;
  bscm_pkg::trk_res_t                  v_res;
  logic                                t_done;
  logic                                v_done;

  logic                                in_range;
  logic [3:0]                          new_flags;
  logic [3:0]                          diffl;
  logic [bscm_pkg::EV_W-1:0]           upd_ev;

  assign req.ready = (state == ST_IDLE);
  assign in_range  = (32'(item.client) < bscm_pkg::CLIENTS);
  assign trk_start = (state == ST_EXEC) && in_range && (item.cmd == bscm_pkg::CMD_UPDATE);

  // Tracker operands from the latched request and the client's context
  always_comb begin
    t_op.sample = {{(bscm_pkg::AVG_W - 12 - bscm_pkg::FRAC_BITS){item.temperature[11]}},
                   item.temperature, {bscm_pkg::FRAC_BITS{1'b0}}};
    t_op.avg    = {temp_avg[item.client][bscm_pkg::TAVG_W-1], temp_avg[item.client]};
    t_op.stamp  = temp_time[item.client];
    t_op.now    = item.now_ms;
    t_op.thr    = {4'b0, temp_thr};
    t_op.tau    = temp_tau;
    v_op.sample = {{(bscm_pkg::AVG_W - 16 - bscm_pkg::FRAC_BITS){1'b0}},
                   item.open_volts, {bscm_pkg::FRAC_BITS{1'b0}}};
    v_op.avg    = volt_avg[item.client];
    v_op.stamp  = volt_time[item.client];
    v_op.now    = item.now_ms;
    v_op.thr    = volt_thr;
    v_op.tau    = volt_tau;
  end

  bscm_track u_temp (
    .clk   (clk),
    .rst   (rst),
    .start (trk_start),
    .op_in (t_op),
    .res   (t_res),
    .done  (t_done)
  );

  bscm_track u_volt (
    .clk   (clk),
    .rst   (rst),
    .start (trk_start),
    .op_in (v_op),
    .res   (v_res),
    .done  (v_done)
  );

  // Build the event set of an update
  always_comb begin
    new_flags = {item.charge_limited, item.sensor_present,
                 item.wireless_present, item.usb_present};
    diffl     = new_flags ^ last_flags[item.client];
    upd_ev    = pending[item.client];
    if (item.charge_percent != last_charge[item.client]) upd_ev[bscm_pkg::EV_CHARGE] = 1'b1;
    if (t_res.jump) upd_ev[bscm_pkg::EV_TEMP] = 1'b1;
    if (v_res.jump) upd_ev[bscm_pkg::EV_VOLT] = 1'b1;
    if (diffl[0]) upd_ev[bscm_pkg::EV_USB] = 1'b1;
    if (diffl[1]) upd_ev[bscm_pkg::EV_WLS] = 1'b1;
    if (item.supply_status != last_supply[item.client]) upd_ev[bscm_pkg::EV_SUPPLY] = 1'b1;
    if (item.charge_status != last_cstat[item.client]) upd_ev[bscm_pkg::EV_CSTAT] = 1'b1;
    if (diffl[2]) upd_ev[bscm_pkg::EV_SENSOR] = 1'b1;
    if (diffl[3]) upd_ev[bscm_pkg::EV_LIMIT] = 1'b1;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_thr <= bscm_pkg::TEMP_THR_RST;
      temp_tau <= bscm_pkg::TEMP_TAU_RST;
      volt_thr <= bscm_pkg::VOLT_THR_RST;
      volt_tau <= bscm_pkg::VOLT_TAU_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bscm_pkg::REG_TEMP_THR: temp_thr <= cfg_data[11:0];
        bscm_pkg::REG_TEMP_TAU: temp_tau <= cfg_data;
        bscm_pkg::REG_VOLT_THR: volt_thr <= cfg_data;
        bscm_pkg::REG_VOLT_TAU: volt_tau <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and client contexts
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      tdone_q <= 1'b0;
      vdone_q <= 1'b0;
      for (int i = 0; i < bscm_pkg::CLIENTS; i++) begin
        last_charge[i] <= '0;
        last_flags[i]  <= '0;
        last_supply[i] <= '0;
        last_cstat[i]  <= '0;
        pending[i]     <= '0;
        temp_avg[i]    <= '0;
        temp_time[i]   <= '0;
        volt_avg[i]    <= '0;
        volt_time[i]   <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            item  <= req.payload;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          tdone_q <= 1'b0;
          vdone_q <= 1'b0;
          if (!in_range) begin
            res_ev <= '0;
            state  <= ST_EMIT;
          end else begin
            unique case (item.cmd)
              bscm_pkg::CMD_UPDATE: state <= ST_WAIT;
              bscm_pkg::CMD_READ: begin
                res_ev               <= pending[item.client];
                pending[item.client] <= '0;
                state                <= ST_EMIT;
              end
              bscm_pkg::CMD_RESET: begin
                res_ev                   <= '0;
                last_charge[item.client] <= '0;
                last_flags[item.client]  <= '0;
                last_supply[item.client] <= '0;
                last_cstat[item.client]  <= '0;
                pending[item.client]     <= '0;
                temp_avg[item.client]    <= '0;
                temp_time[item.client]   <= '0;
                volt_avg[item.client]    <= '0;
                volt_time[item.client]   <= '0;
                state                    <= ST_EMIT;
              end
              bscm_pkg::CMD_PEEK: begin
                res_ev <= pending[item.client];
                state  <= ST_EMIT;
              end
              default: state <= ST_EMIT;
            endcase
          end
        end
        ST_WAIT: begin
          // hold until both trackers finish; results stay in their registers
          if (t_done) tdone_q <= 1'b1;
          if (v_done) vdone_q <= 1'b1;
          if ((tdone_q || t_done) && (vdone_q || v_done)) begin
            pending[item.client]     <= upd_ev;
            res_ev                   <= upd_ev;
            last_charge[item.client] <= item.charge_percent;
            last_flags[item.client]  <= new_flags;
            last_supply[item.client] <= item.supply_status;
            last_cstat[item.client]  <= item.charge_status;
            temp_avg[item.client]    <= t_res.avg[bscm_pkg::TAVG_W-1:0];
            temp_time[item.client]   <= t_res.stamp;
            volt_avg[item.client]    <= v_res.avg;
            volt_time[item.client]   <= v_res.stamp;
            state                    <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!rsp.valid || rsp.ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_EMIT && (!rsp.valid || rsp.ready)) begin
      rsp.valid   <= 1'b1;
      rsp.payload <= bscm_pkg::to_rsp(res_ev);
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

endmodule

// ===== tb/battery_state_change_monitor_tb.sv =====
// Testbench for the battery state change monitor: directed table, random traffic, predictor.
module battery_state_change_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bscm_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT  = 80;
  localparam int PHASE_ITEMS = 350;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  bscm_req_if req ();
  bscm_rsp_if rsp ();

  battery_state_change_monitor DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: per-client context and a copy of the registers
  logic [6:0]  pr_charge [CLIENTS];
  logic [3:0]  pr_bits   [CLIENTS];
  logic [3:0]  pr_supply [CLIENTS];
  logic [2:0]  pr_cstat  [CLIENTS];
  logic [8:0]  pr_events [CLIENTS];
  longint      pr_tavg   [CLIENTS];
  logic [31:0] pr_ttime  [CLIENTS];
  longint      pr_vavg   [CLIENTS];
  logic [31:0] pr_vtime  [CLIENTS];
  logic [11:0] m_temp_thr;
  logic [15:0] m_temp_tau, m_volt_thr, m_volt_tau;

  rsp_t        flags_due [$];
  int          fails, n_sent, n_checked, n_jumps, cycles;
  bit          pin_on;
  rsp_t        pin_val;
  bit          no_idle, long_hold;

  // Stimulus-side view of each client for well-formed sequences
  logic [31:0] st_now  [CLIENTS];
  req_t        st_last [CLIENTS];

  typedef struct {
    req_t r;
    bit   pinned;
    rsp_t e;
  } row_t;

  function automatic rsp_t flags_out(input logic [8:0] ev);
    rsp_t o;
    o = '{any_pending: |ev, charge_changed: ev[0], temp_jump: ev[1], volt_jump: ev[2],
          usb_changed: ev[3], wireless_changed: ev[4], supply_changed: ev[5],
          charge_status_changed: ev[6], sensor_changed: ev[7], limit_changed: ev[8]};
    return o;
  endfunction

  // Advance one moving average; report a jump
  function automatic bit smooth(input longint sample, inout longint avg,
                                inout logic [31:0] stamp, input logic [15:0] thr,
                                input logic [15:0] tau, input logic [31:0] now);
    longint scaled, diff;
    longint unsigned mag, dt, q;
    scaled = sample * (longint'(1) << FRAC_BITS);
    if (stamp == 0) begin
      avg = scaled;
      stamp = now;
      return 0;
    end
    dt = longint'(now - stamp) & 64'hFFFF_FFFF;
    stamp = now;
    if (dt == 0) return 0;
    diff = scaled - avg;
    mag = (diff < 0) ? -diff : diff;
    if (mag >= (longint'(thr) << FRAC_BITS)) begin
      avg = scaled;
      return 1;
    end
    q = (mag * dt) / (longint'(tau) + dt);
    if (diff < 0) avg = avg - longint'(q);
    else avg = avg + longint'(q);
    return 0;
  endfunction

  function automatic rsp_t predict_flags(input req_t r);
    int c;
    logic [8:0] ev;
    logic [3:0] nb, db;
    c = r.client;
    case (r.cmd)
      CMD_READ: begin
        ev = pr_events[c];
        pr_events[c] = '0;
        return flags_out(ev);
      end
      CMD_RESET: begin
        pr_charge[c] = '0; pr_bits[c] = '0; pr_supply[c] = '0; pr_cstat[c] = '0;
        pr_events[c] = '0; pr_tavg[c] = 0; pr_ttime[c] = '0;
        pr_vavg[c] = 0; pr_vtime[c] = '0;
        return flags_out('0);
      end
      CMD_PEEK: return flags_out(pr_events[c]);
      default: begin
        ev = pr_events[c];
        nb = {r.charge_limited, r.sensor_present, r.wireless_present, r.usb_present};
        db = nb ^ pr_bits[c];
        if (r.charge_percent != pr_charge[c]) ev[0] = 1'b1;
        if (smooth(longint'(r.temperature), pr_tavg[c], pr_ttime[c], 16'(m_temp_thr),
                   m_temp_tau, r.now_ms)) ev[1] = 1'b1;
        if (smooth(longint'({1'b0, r.open_volts}), pr_vavg[c], pr_vtime[c], m_volt_thr,
                   m_volt_tau, r.now_ms)) ev[2] = 1'b1;
        if (db[0]) ev[3] = 1'b1;
        if (db[1]) ev[4] = 1'b1;
        if (r.supply_status != pr_supply[c]) ev[5] = 1'b1;
        if (r.charge_status != pr_cstat[c]) ev[6] = 1'b1;
        if (db[2]) ev[7] = 1'b1;
        if (db[3]) ev[8] = 1'b1;
        pr_events[c] = ev;
        pr_charge[c] = r.charge_percent;
        pr_bits[c] = nb;
        pr_supply[c] = r.supply_status;
        pr_cstat[c] = r.charge_status;
        return flags_out(ev);
      end
    endcase
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, flags_due.size());
      $display("battery_state_change_monitor_tb: FAIL");
      $finish;
    end
  end

  // Predict each accepted request, check each accepted response
  always @(posedge clk) begin
    rsp_t p, got, want;
    if (!rst && req.valid && req.ready) begin
      p = predict_flags(req.payload);
      if (pin_on && p != pin_val)
        $display("%0t: note: predictor %b differs from table %b", $time, p, pin_val);
      flags_due.push_back(pin_on ? pin_val : p);
    end
    if (!rst && rsp.valid && rsp.ready) begin
      got = rsp.payload;
      if (flags_due.size() == 0) begin
        $display("%0t: unexpected response %b", $time, got);
        fails++;
      end else begin
        want = flags_due.pop_front();
        n_checked++;
        if (got.temp_jump || got.volt_jump) n_jumps++;
        if (got != want) begin
          $display("%0t: response mismatch: expected %b, actual %b", $time, want, got);
          fails++;
        end
      end
    end
  end

  // Response side: random stall bursts, one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        rsp.ready = 1'b0;
        hold--;
      end else if (long_hold) begin
        long_hold = 0;
        rsp.ready = 1'b0;
        hold = 400;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        rsp.ready = 1'b0;
        hold = $urandom_range(0, 6);
      end else begin
        rsp.ready = 1'b1;
      end
    end
  end

  // Offer one transaction and hold it until accepted
  task automatic send_txn(input req_t r, input bit pinned, input rsp_t e);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      req.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    req.payload = r;
    pin_on = pinned;
    pin_val = e;
    req.valid = 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    n_sent++;
    if (r.cmd == CMD_UPDATE) begin
      st_now[r.client] = r.now_ms;
      st_last[r.client] = r;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    req.valid = 1'b0;
    pin_on = 0;
    while (flags_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_TEMP_THR: m_temp_thr = val[11:0];
      REG_TEMP_TAU: m_temp_tau = val;
      REG_VOLT_THR: m_volt_thr = val;
      default:      m_volt_tau = val;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] tthr, input logic [15:0] ttau,
                          input logic [15:0] vthr, input logic [15:0] vtau);
    drain();
    write_reg(REG_TEMP_THR, tthr);
    write_reg(REG_TEMP_TAU, ttau);
    write_reg(REG_VOLT_THR, vthr);
    write_reg(REG_VOLT_TAU, vtau);
  endtask

  // Build a random transaction: mostly plausible sample streams per client
  function automatic req_t random_txn();
    req_t r;
    int c, pick;
    c = $urandom_range(0, CLIENTS - 1);
    r = st_last[c];
    r.client = 3'(c);
    pick = $urandom_range(0, 99);
    if (pick < 72) r.cmd = CMD_UPDATE;
    else if (pick < 88) r.cmd = CMD_READ;
    else if (pick < 94) r.cmd = CMD_PEEK;
    else r.cmd = CMD_RESET;
    if (r.cmd != CMD_UPDATE) r.now_ms = $urandom;
    else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) r.now_ms = st_now[c] + $urandom_range(1, 3000);
      else if (pick < 80) r.now_ms = st_now[c];
      else if (pick < 90) r.now_ms = st_now[c] + $urandom;
      else if (pick < 95) r.now_ms = '0;
      else r.now_ms = $urandom;
      if ($urandom_range(0, 3) == 0) r.charge_percent = 7'($urandom_range(0, 100));
      if ($urandom_range(0, 4) == 0) r.temperature = 12'($urandom);
      else r.temperature = r.temperature + 12'($signed($urandom_range(0, 120)) - 60);
      if ($urandom_range(0, 4) == 0) r.open_volts = 16'($urandom);
      else r.open_volts = r.open_volts + 16'($signed($urandom_range(0, 800)) - 400);
      if ($urandom_range(0, 5) == 0) r.usb_present = ~r.usb_present;
      if ($urandom_range(0, 5) == 0) r.wireless_present = ~r.wireless_present;
      if ($urandom_range(0, 5) == 0) r.sensor_present = ~r.sensor_present;
      if ($urandom_range(0, 5) == 0) r.charge_limited = ~r.charge_limited;
      if ($urandom_range(0, 4) == 0) r.supply_status = 4'($urandom);
      if ($urandom_range(0, 4) == 0) r.charge_status = 3'($urandom);
    end
    return r;
  endfunction

  function automatic req_t mk(input logic [1:0] cmd, input logic [2:0] c, input logic [31:0] t,
                              input logic [6:0] ch, input logic [11:0] tp,
                              input logic [15:0] v, input logic [3:0] bits,
                              input logic [3:0] sup, input logic [2:0] cs);
    req_t r;
    r = '{cmd: cmd, client: c, now_ms: t, charge_percent: ch, temperature: tp,
          open_volts: v, usb_present: bits[0], wireless_present: bits[1],
          supply_status: sup, charge_status: cs, sensor_present: bits[2],
          charge_limited: bits[3]};
    return r;
  endfunction

  initial begin
    row_t   dir_rows [$];
    rsp_t   zero_f, full_f;
    int     phase;
    fails = 0; n_sent = 0; n_checked = 0; n_jumps = 0; cycles = 0;
    no_idle = 0; long_hold = 0; pin_on = 0; pin_val = '0;
    req.valid = 1'b0;
    req.payload = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    for (int i = 0; i < CLIENTS; i++) begin
      pr_charge[i] = '0; pr_bits[i] = '0; pr_supply[i] = '0; pr_cstat[i] = '0;
      pr_events[i] = '0; pr_tavg[i] = 0; pr_ttime[i] = '0; pr_vavg[i] = 0;
      pr_vtime[i] = '0; st_now[i] = 32'd1; st_last[i] = '0;
    end
    m_temp_thr = TEMP_THR_RST; m_temp_tau = TEMP_TAU_RST;
    m_volt_thr = VOLT_THR_RST; m_volt_tau = VOLT_TAU_RST;

    // Hold reset
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    zero_f = '0;
    full_f = '{any_pending: 1, charge_changed: 1, temp_jump: 0, volt_jump: 0,
               usb_changed: 1, wireless_changed: 1, supply_changed: 1,
               charge_status_changed: 1, sensor_changed: 1, limit_changed: 1};

    // Directed table: extremes, every command, seeding, jumps, wrap, zero dt
    dir_rows = '{
      '{mk(CMD_UPDATE, 0, 32'd0, 0, 12'h000, 16'h0000, 4'h0, 0, 0), 1, zero_f},
      '{mk(CMD_UPDATE, 1, 32'hFFFF_FFFF, 100, 12'h7FF, 16'hFFFF, 4'hF, 15, 7), 1, full_f},
      '{mk(CMD_PEEK,   1, 32'd0, 0, 12'h000, 16'h0000, 4'h0, 0, 0), 1, full_f},
      '{mk(CMD_READ,   1, 32'd0, 0, 12'h000, 16'h0000, 4'h0, 0, 0), 1, full_f},
      '{mk(CMD_READ,   1, 32'd0, 0, 12'h000, 16'h0000, 4'h0, 0, 0), 1, zero_f},
      '{mk(CMD_RESET,  2, 32'd0, 0, 12'h000, 16'h0000, 4'h0, 0, 0), 1, zero_f},
      '{mk(CMD_UPDATE, 0, 32'd0, 0, 12'h000, 16'h0000, 4'h0, 0, 0), 1, zero_f},
      '{mk(CMD_UPDATE, 0, 32'd100, 0, 12'h000, 16'h0000, 4'h0, 0, 0), 1, zero_f},
      '{mk(CMD_UPDATE, 0, 32'd200, 0, 12'h800, 16'hFFFF, 4'h0, 0, 0), 0, zero_f},
      '{mk(CMD_UPDATE, 0, 32'd300, 0, 12'h7FF, 16'h0000, 4'h0, 0, 0), 0, zero_f},
      '{mk(CMD_UPDATE, 0, 32'd400, 0, 12'h7F0, 16'h0100, 4'h0, 0, 0), 0, zero_f},
      '{mk(CMD_UPDATE, 0, 32'd400, 0, 12'h000, 16'h0000, 4'h0, 0, 0), 0, zero_f},
      '{mk(CMD_UPDATE, 0, 32'd9000, 0, 12'h7C0, 16'h00FF, 4'h0, 0, 0), 0, zero_f},
      '{mk(CMD_UPDATE, 1, 32'd20, 100, 12'h7FF, 16'hFFF0, 4'hF, 15, 7), 0, zero_f},
      '{mk(CMD_UPDATE, 1, 32'd40, 64, 12'h7E0, 16'hFF00, 4'h5, 8, 4), 0, zero_f},
      '{mk(CMD_READ,   0, 32'd0, 0, 12'h000, 16'h0000, 4'h0, 0, 0), 0, zero_f},
      '{mk(CMD_READ,   1, 32'd0, 0, 12'h000, 16'h0000, 4'h0, 0, 0), 0, zero_f},
      '{mk(CMD_UPDATE, 7, 32'd5, 1, 12'hFFF, 16'h0001, 4'hA, 1, 1), 0, zero_f},
      '{mk(CMD_PEEK,   7, 32'd0, 0, 12'h000, 16'h0000, 4'h0, 0, 0), 0, zero_f},
      '{mk(CMD_RESET,  7, 32'd0, 0, 12'h000, 16'h0000, 4'h0, 0, 0), 1, zero_f},
      '{mk(CMD_READ,   7, 32'd0, 0, 12'h000, 16'h0000, 4'h0, 0, 0), 1, zero_f}
    };
    foreach (dir_rows[i]) send_txn(dir_rows[i].r, dir_rows[i].pinned, dir_rows[i].e);

    // Random phases, each under its own register setting
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_regs(16'(TEMP_THR_RST), TEMP_TAU_RST, VOLT_THR_RST, VOLT_TAU_RST);
        1: set_regs(16'd0, 16'd1, 16'd0, 16'd1);
        2: set_regs(16'd4095, 16'd65535, 16'd65535, 16'd65535);
        3: set_regs(16'd24, 16'd1, 16'd200, 16'd40000);
        default: begin
          set_regs(16'($urandom_range(1, 4095)), 16'($urandom_range(1, 65535)),
                   16'($urandom_range(1, 3000)), 16'($urandom_range(1, 65535)));
          no_idle = 1;
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 1 && k == 100) long_hold = 1;
        if (k == PHASE_ITEMS / 2) drain();
        send_txn(random_txn(), 0, zero_f);
      end
    end

    // Let every response come back
    drain();
    $display("Sent %0d transactions, checked %0d responses (%0d with jump flags)",
             n_sent, n_checked, n_jumps);
    $display("Covered all commands, 5 register settings, seeding, wrap, zero dt, back-pressure");
    if (fails == 0) begin
      $display("battery_state_change_monitor_tb: PASS");
    end else begin
      $display("%0d mismatches", fails);
      $display("battery_state_change_monitor_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bscm_pkg.sv
rtl/core/bscm_if.sv
rtl/core/bscm_track.sv
rtl/core/battery_state_change_monitor.sv
tb/battery_state_change_monitor_tb.sv
